// ===== hw/rtl/cfwr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfwr_pkg
// Shared types and constants for the circular FIFO with order reversal.
// ----------------------------------------------------------------------------
package cfwr_pkg;

    localparam int CFWR_DEPTH      = 16;
    localparam int CFWR_DATA_WIDTH = 32;

    // capacity register and occupancy are fixed at 5 bits
    localparam int CAP_W = 5;
    localparam int CNT_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_PEEK = 2'd2,
        FN_REV  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // per-word result info handed from the pointer logic to the result stage
    typedef struct packed {
        logic             rd;
        status_t          status;
        logic [CNT_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
    } res_t;

endpackage

// ===== hw/rtl/circular_fifo_with_reverse_core.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_reverse_core
// Ring FIFO of signed words with enqueue, dequeue, peek and order reversal.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (func, value) is taken at a rising edge with
//   start high and busy low. busy is high only during and just after reset
//   and while a configuration write is offered.
//   Result channel: done pulses for one cycle with data, status, occupancy,
//   is_empty and is_full, in the cycle after the command was taken.
//   The receiver cannot stall; every result must be captured on the strobe.
//   Throughput is one command per cycle while busy is low: the pointer
//   update and the slot read of the synchronous slot RAM happen at the same edge.
//   Configuration: cfg_valid/cfg_ready write the capacity (1..DEPTH, 0 acts
//   as 1, larger acts as DEPTH) and empty the queue. Write only when idle.
//   Reset empties the queue, sets capacity to 16 and forward order. Slot
//   contents are not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
module circular_fifo_with_reverse_core #(
    parameter int DEPTH      = cfwr_pkg::CFWR_DEPTH,
    parameter int DATA_WIDTH = cfwr_pkg::CFWR_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic [1:0]                   status,
    output logic [cfwr_pkg::CNT_W-1:0]   occupancy,
    output logic                         is_empty,
    output logic                         is_full,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cfwr_pkg::CAP_W-1:0]   cfg_data
);
    import cfwr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  init_reg;
    logic                  acc;
    logic                  cfg_we;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  done_reg;

    // hold off commands right after reset and while a config write is offered
    assign busy      = init_reg | cfg_valid;
    assign cfg_ready = ~init_reg;
    assign acc       = start & ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= 1'b0;
        end
    end

    cfwr_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .func      (func),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res_next)
    );

    cfwr_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_reg <= res_next;
        end
    end

    // read data comes straight from the RAM output register
    always_comb
    begin
        if (res_reg.rd)
        begin
            data = mem_rdata;
        end
        else if (res_reg.status == ST_EMPTY)
        begin
            data = WORD_MIN;
        end
        else
        begin
            data = '0;
        end
    end

    assign done      = done_reg;
    assign status    = res_reg.status;
    assign occupancy = res_reg.occupancy;
    assign is_empty  = res_reg.is_empty;
    assign is_full   = res_reg.is_full;

endmodule

// ===== hw/rtl/cfwr_mem.sv =====
// ----------------------------------------------------------------------------
// cfwr_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfwr_mem #(
    parameter int DEPTH      = cfwr_pkg::CFWR_DEPTH,
    parameter int DATA_WIDTH = cfwr_pkg::CFWR_DATA_WIDTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);
    import cfwr_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/cfwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfwr_ctrl
// Ring pointers, entry count, direction bit and capacity register.
// ----------------------------------------------------------------------------
module cfwr_ctrl #(
    parameter int DEPTH      = cfwr_pkg::CFWR_DEPTH,
    parameter int DATA_WIDTH = cfwr_pkg::CFWR_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         acc,
    input  logic [1:0]                   func,
    input  logic [DATA_WIDTH-1:0]        value,
    input  logic                         cfg_we,
    input  logic [cfwr_pkg::CAP_W-1:0]   cfg_data,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic [DATA_WIDTH-1:0]        mem_wdata,
    output logic                         mem_re,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr,
    output cfwr_pkg::res_t               res
);
    import cfwr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CAP_W-1:0] cap_reg,  cap_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             rev_reg,  rev_next;

    logic [CW-1:0]    eff_cap;
    logic [IDX_W-1:0] front;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] tail_inc;
    logic [IDX_W-1:0] tail_dec;
    logic [IDX_W-1:0] head_inc;
    logic             full;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] iw;
        iw = CW'(i) + CW'(1);
        return (iw >= cap) ? '0 : iw[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] cm1;
        cm1 = cap - CW'(1);
        return ((i == '0) || (CW'(i) >= cap)) ? cm1[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

    // clamp the register into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(cap_reg) > DEPTH_C)
        begin
            eff_cap = DEPTH_C;
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign head_dec = idx_dec(head_reg, eff_cap);
    assign head_inc = idx_inc(head_reg, eff_cap);
    assign tail_dec = idx_dec(tail_reg, eff_cap);
    assign tail_inc = idx_inc(tail_reg, eff_cap);
    assign front    = rev_reg ? tail_dec : head_reg;
    assign full     = (CW'(cnt_reg) >= eff_cap);

    always_comb
    begin
        cap_next  = cap_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        rev_next  = rev_reg;
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = value;
        mem_re    = 1'b0;
        mem_raddr = front;
        res.rd    = 1'b0;
        res.status = ST_DONE;

        if (cfg_we)
        begin
            // new capacity: drop everything
            cap_next  = cfg_data;
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
            rev_next  = 1'b0;
        end
        else if (acc)
        begin
            case (func_t'(func))
                FN_ENQ:
                begin
                    if (full)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (rev_reg)
                        begin
                            // reversed: back of queue sits below head
                            mem_waddr = head_dec;
                            head_next = head_dec;
                        end
                        else
                        begin
                            mem_waddr = tail_reg;
                            tail_next = tail_inc;
                        end
                    end
                end
                FN_DEQ, FN_PEEK:
                begin
                    if (cnt_reg == '0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        res.rd = 1'b1;
                        if (func_t'(func) == FN_DEQ)
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            if (rev_reg)
                            begin
                                tail_next = tail_dec;
                            end
                            else
                            begin
                                head_next = head_inc;
                            end
                            if (cnt_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                                rev_next  = 1'b0;
                            end
                        end
                    end
                end
                FN_REV:
                begin
                    if (cnt_reg != '0)
                    begin
                        rev_next = ~rev_reg;
                    end
                end
                default:
                begin
                    rev_next = rev_reg;
                end
            endcase
        end

        res.occupancy = cnt_next;
        res.is_empty  = (cnt_next == '0);
        res.is_full   = (CW'(cnt_next) == eff_cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            rev_reg  <= 1'b0;
        end
        else
        begin
            cap_reg  <= cap_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            rev_reg  <= rev_next;
        end
    end

endmodule

// ===== hw/rtl/cfwr_checker.sv =====
// ----------------------------------------------------------------------------
// cfwr_checker
// Port-level checks for the circular FIFO core, bound to the top level.
// ----------------------------------------------------------------------------
module cfwr_checker #(
    parameter int DATA_WIDTH = cfwr_pkg::CFWR_DATA_WIDTH
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [DATA_WIDTH-1:0]      data,
    input logic [1:0]                 status,
    input logic [cfwr_pkg::CNT_W-1:0] occupancy,
    input logic                       is_empty,
    input logic                       is_full
);
    import cfwr_pkg::*;

    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // every taken command answers in the next cycle
    a_cmd_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command taken without a result one cycle later");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result strobe without a taken command");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (data == WORD_MIN && is_empty))
        else $error("empty read must return the most negative word");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (is_full && !is_empty))
        else $error("dropped enqueue while queue not full");

endmodule

bind circular_fifo_with_reverse_core cfwr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cfwr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .data      (data),
    .status    (status),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full)
);

// ===== verif/circular_fifo_with_reverse_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_reverse_core_test
// Self-checking bench for the ring FIFO with order reversal. A predictor
// tracks slots, pointers, count, direction and capacity; every result word
// is compared field by field against the oldest prediction. Directed cases
// come first, then random phases over several capacities and idle patterns.
// ----------------------------------------------------------------------------
module circular_fifo_with_reverse_core_test;
    import cfwr_pkg::*;

    localparam int WDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] data;
        status_t            status;
        logic [CNT_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
    } fifo_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          func;
    logic signed [31:0]  value;
    logic                done;
    logic signed [31:0]  data;
    logic [1:0]          status;
    logic [CNT_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data;

    // predictor state
    logic signed [31:0]  slots [CFWR_DEPTH];
    int                  head_idx;
    int                  tail_idx;
    int                  entry_cnt;
    bit                  rev_order;
    logic [CAP_W-1:0]    cap_reg;

    fifo_result_t        pending_results [$];
    int                  error_cnt;
    int                  stall_cycles;
    int                  idle_pct;

    circular_fifo_with_reverse_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .value     (value),
        .done      (done),
        .data      (data),
        .status    (status),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int step_fwd(int i, int cap);
        return (i + 1 >= cap) ? 0 : i + 1;
    endfunction

    function automatic int step_back(int i, int cap);
        return (i == 0 || i >= cap) ? cap - 1 : i - 1;
    endfunction

    function automatic void clear_queue();
        head_idx  = 0;
        tail_idx  = 0;
        entry_cnt = 0;
        rev_order = 1'b0;
    endfunction

    function automatic fifo_result_t predict_op(func_t op, logic signed [31:0] word);
        fifo_result_t r;
        int cap;
        int front;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > CFWR_DEPTH) ? CFWR_DEPTH : int'(cap_reg));
        front = rev_order ? step_back(tail_idx, cap) : head_idx;
        r.data = '0;
        r.status = ST_DONE;
        case (op)
            FN_ENQ:
            begin
                if (entry_cnt >= cap)
                    r.status = ST_FULL;
                else if (rev_order)
                begin
                    // front sits at the tail end, so the back grows downward
                    head_idx = step_back(head_idx, cap);
                    slots[head_idx] = word;
                    entry_cnt++;
                end
                else
                begin
                    slots[tail_idx] = word;
                    tail_idx = step_fwd(tail_idx, cap);
                    entry_cnt++;
                end
            end
            FN_DEQ, FN_PEEK:
            begin
                if (entry_cnt == 0)
                begin
                    r.data = WORD_MIN;
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.data = slots[front];
                    if (op == FN_DEQ)
                    begin
                        if (rev_order)
                            tail_idx = step_back(tail_idx, cap);
                        else
                            head_idx = step_fwd(head_idx, cap);
                        entry_cnt--;
                        if (entry_cnt == 0)
                            clear_queue();
                    end
                end
            end
            default:
            begin
                if (entry_cnt != 0)
                    rev_order = !rev_order;
            end
        endcase
        r.occupancy = entry_cnt[CNT_W-1:0];
        r.is_empty = (entry_cnt == 0);
        r.is_full = (entry_cnt == cap);
        return r;
    endfunction

    task automatic note_error(string msg);
        if (error_cnt < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_cnt++;
    endtask

    // check each result word, then predict the word accepted at this edge
    always @(posedge clk)
    begin
        fifo_result_t exp_res;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    note_error("result word with nothing expected");
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (data !== exp_res.data)
                        note_error($sformatf("data exp %0d got %0d", exp_res.data, data));
                    if (status !== exp_res.status)
                        note_error($sformatf("status exp %0d got %0d",
                                             exp_res.status, status));
                    if (occupancy !== exp_res.occupancy)
                        note_error($sformatf("occupancy exp %0d got %0d",
                                             exp_res.occupancy, occupancy));
                    if (is_empty !== exp_res.is_empty)
                        note_error($sformatf("is_empty exp %0b got %0b",
                                             exp_res.is_empty, is_empty));
                    if (is_full !== exp_res.is_full)
                        note_error($sformatf("is_full exp %0b got %0b",
                                             exp_res.is_full, is_full));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = cfg_data;
                clear_queue();
            end
            if (start && !busy)
                pending_results.push_back(predict_op(func_t'(func), value));
        end
        if (done || (start && !busy) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_op(func_t op, logic signed [31:0] word);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= op;
        value <= word;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off new commands until every expected word has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_and_reverse();
        send_op(FN_PEEK, 32'sd7);
        send_op(FN_DEQ, WORD_MAX);
        send_op(FN_REV, -32'sd1);
        send_op(FN_ENQ, WORD_MIN);
        send_op(FN_ENQ, WORD_MAX);
        send_op(FN_ENQ, 32'sd0);
        send_op(FN_ENQ, -32'sd1);
        send_op(FN_PEEK, 32'sd0);
        send_op(FN_REV, 32'sd0);
        send_op(FN_PEEK, 32'sd0);
        send_op(FN_ENQ, 32'sh5555_5555);
        send_op(FN_DEQ, 32'sd0);
        send_op(FN_REV, 32'sd0);
        repeat (5) send_op(FN_DEQ, 32'sd0);
    endtask

    task automatic test_capacity_limits();
        // zero acts as one slot
        write_capacity(5'd0);
        send_op(FN_ENQ, 32'shAAAA_AAAA);
        send_op(FN_ENQ, 32'sd1);
        send_op(FN_REV, 32'sd0);
        send_op(FN_DEQ, 32'sd0);
        // above the depth acts as the depth
        write_capacity(5'd31);
        repeat (2) send_op(FN_ENQ, $urandom);
    endtask

    task automatic test_random_ops(logic [CAP_W-1:0] cap, int n_ops, int enq_pct);
        logic signed [31:0] word;
        func_t op;
        write_capacity(cap);
        repeat (n_ops)
        begin
            case ($urandom_range(15))
                0: word = WORD_MIN;
                1: word = WORD_MAX;
                default: word = $urandom;
            endcase
            if ($urandom_range(99) < enq_pct)
                op = FN_ENQ;
            else
            begin
                case ($urandom_range(2))
                    0: op = FN_DEQ;
                    1: op = FN_PEEK;
                    default: op = FN_REV;
                endcase
            end
            send_op(op, word);
        end
    endtask

    initial
    begin
        start <= 1'b0;
        func <= FN_ENQ;
        value <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        error_cnt = 0;
        stall_cycles = 0;
        idle_pct = 17;
        cap_reg = CAP_RESET;
        clear_queue();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_reverse();
        test_capacity_limits();

        test_random_ops(5'd16, 100, 60);
        test_random_ops(5'd1, 60, 45);
        test_random_ops(5'($urandom_range(2, 15)), 100, 50);
        idle_pct = 88;
        test_random_ops(5'd0, 60, 50);
        test_random_ops(5'd31, 100, 55);
        test_random_ops(5'($urandom_range(2, 15)), 100, 45);
        idle_pct = 0;
        test_random_ops(5'd17, 100, 65);
        test_random_ops(5'd16, 100, 35);
        test_random_ops(5'($urandom_range(1, 16)), 80, 50);

        drain_results();
        repeat (3) @(posedge clk);
        if (error_cnt == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
